### sv/cke_pkg.sv
// shared constants and base decoding for the canonical k-mer extractor
package cke_pkg;

	localparam int MAX_K_DEF = 32;
	localparam int KMER_W    = 64;

	localparam logic [5:0] K_RESET     = 6'd21;
	localparam logic       CANON_RESET = 1'b1;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_MODE = 8'd1;

	localparam logic [7:0] CHAR_GT = 8'h3E;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	typedef struct packed {
		logic       is_base;
		logic [1:0] code;
	} base_t;

	function automatic base_t base_code(input logic [7:0] b);
		base_t r;
		r.is_base = 1'b1;
		r.code    = 2'd0;
		case (b)
			8'h41, 8'h61: r.code = 2'd0;
			8'h43, 8'h63: r.code = 2'd1;
			8'h47, 8'h67: r.code = 2'd2;
			8'h54, 8'h74, 8'h55, 8'h75: r.code = 2'd3;
			default: r.is_base = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### sv/cke_parse.sv
// record parser with rolling forward and reverse-complement windows
module cke_parse #(
	parameter int MAX_K = cke_pkg::MAX_K_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [7:0]                  byte_s1,
	input  logic [$clog2(MAX_K+1)-1:0]  keff,
	output logic                        emit,
	output logic [2*MAX_K-1:0]          fwd_next,
	output logic [2*MAX_K-1:0]          rev_next
);
	import cke_pkg::*;

	localparam int WIN_W = 2 * MAX_K;
	localparam int RUN_W = $clog2(MAX_K + 1);

	localparam logic [1:0] MODE_PREAMBLE = 2'd0;
	localparam logic [1:0] MODE_HEADER   = 2'd1;
	localparam logic [1:0] MODE_SEQUENCE = 2'd2;

	logic [1:0]       mode_q, mode_next;
	logic [WIN_W-1:0] fwd_q, rev_q;
	logic [RUN_W-1:0] run_q, run_next;
	base_t            bc;

	always_comb begin
		bc        = base_code(byte_s1);
		mode_next = mode_q;
		fwd_next  = fwd_q;
		rev_next  = rev_q;
		run_next  = run_q;
		emit      = 1'b0;
		unique case (mode_q)
			MODE_PREAMBLE: begin
				if (byte_s1 == CHAR_GT) begin
					mode_next = MODE_HEADER;
					fwd_next  = '0;
					rev_next  = '0;
					run_next  = '0;
				end
			end
			MODE_HEADER: begin
				if (byte_s1 == CHAR_LF)
					mode_next = MODE_SEQUENCE;
			end
			MODE_SEQUENCE: begin
				if (byte_s1 == CHAR_GT) begin
					mode_next = MODE_HEADER;
					fwd_next  = '0;
					rev_next  = '0;
					run_next  = '0;
				end else if (byte_s1 == CHAR_LF || byte_s1 == CHAR_CR) begin
					// line breaks inside sequence keep the run going
				end else if (!bc.is_base) begin
					fwd_next = '0;
					rev_next = '0;
					run_next = '0;
				end else begin
					fwd_next = (fwd_q << 2) | WIN_W'(bc.code);
					rev_next = (rev_q >> 2) | (WIN_W'(~bc.code) << (WIN_W - 2));
					if (run_q < RUN_W'(MAX_K))
						run_next = run_q + RUN_W'(1);
					emit = (run_next >= keff);
				end
			end
			default: mode_next = MODE_PREAMBLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PREAMBLE;
			fwd_q  <= '0;
			rev_q  <= '0;
			run_q  <= '0;
		end else if (adv) begin
			mode_q <= mode_next;
			fwd_q  <= fwd_next;
			rev_q  <= rev_next;
			run_q  <= run_next;
		end
	end

endmodule

### sv/cke_select.sv
// k-mer cut from the windows and canonical choice
module cke_select #(
	parameter int MAX_K = cke_pkg::MAX_K_DEF
) (
	input  logic [2*MAX_K-1:0]          fwd_win,
	input  logic [2*MAX_K-1:0]          rev_win,
	input  logic [$clog2(MAX_K+1)-1:0]  keff,
	input  logic                        canon,
	output logic [cke_pkg::KMER_W-1:0]  kmer,
	output logic                        from_rev
);
	import cke_pkg::*;

	localparam int WIN_W = 2 * MAX_K;
	localparam int RUN_W = $clog2(MAX_K + 1);

	logic [RUN_W:0]   shift;
	logic [WIN_W-1:0] mask, fwd, rc;

	always_comb begin
		// unused high pairs: twice the bases missing from a full window
		shift    = {RUN_W'(MAX_K) - keff, 1'b0};
		mask     = {WIN_W{1'b1}} >> shift;
		fwd      = fwd_win & mask;
		rc       = rev_win >> shift;
		from_rev = canon && (rc < fwd);
		kmer     = from_rev ? KMER_W'(rc) : KMER_W'(fwd);
	end

endmodule

### sv/canonical_kmer_extractor.sv
// top level of the canonical k-mer extractor
// Takes one byte of FASTA text per word on the input channel and, for each base that
// completes a run of at least k valid bases, delivers one k-mer word (2k bits, first
// base in the most significant pair, A=0 C=1 G=2 T=3), optionally canonicalized
// against its reverse complement with from_reverse flagging that choice. Bytes
// before the first '>' and header lines are dropped, CR/LF in sequence lines are
// skipped, and any other non-base byte restarts the run. The block sustains one byte
// per cycle while the output side keeps taking words: a byte sits in the input
// register while the parser, windows and compare resolve, and the result lands in
// the output register, so throughput is set only by the output side taking words. k
// values of 0 act as 1 and values above MAX_K act as MAX_K. Configuration writes are
// always taken and should be issued while no byte is in flight.
module canonical_kmer_extractor #(
	parameter int MAX_K = cke_pkg::MAX_K_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     byte_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cke_pkg::KMER_W-1:0]     canonical_kmer,
	output logic                           from_reverse,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cke_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cke_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import cke_pkg::*;

	localparam int WIN_W = 2 * MAX_K;
	localparam int RUN_W = $clog2(MAX_K + 1);

	logic [5:0]       kmer_length_q;
	logic             canon_q;
	logic [RUN_W-1:0] keff;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             adv;
	logic             emit;
	logic [WIN_W-1:0] fwd_next, rev_next;
	logic [KMER_W-1:0] kmer;
	logic             from_rev;
	logic             out_valid_q;
	logic [KMER_W-1:0] kmer_q;
	logic             from_rev_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= K_RESET;
			canon_q       <= CANON_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KMER_LENGTH:    kmer_length_q <= cfg_data[5:0];
				CFG_CANONICAL_MODE: canon_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (kmer_length_q == 6'd0)
			keff = RUN_W'(1);
		else if (7'(kmer_length_q) > 7'(MAX_K))
			keff = RUN_W'(MAX_K);
		else
			keff = RUN_W'(kmer_length_q);
	end

	// input word moves on when the output slot is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= byte_in;
	end

	cke_parse #(.MAX_K(MAX_K)) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.byte_s1  (byte_s1),
		.keff     (keff),
		.emit     (emit),
		.fwd_next (fwd_next),
		.rev_next (rev_next)
	);

	cke_select #(.MAX_K(MAX_K)) u_select (
		.fwd_win  (fwd_next),
		.rev_win  (rev_next),
		.keff     (keff),
		.canon    (canon_q),
		.kmer     (kmer),
		.from_rev (from_rev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= emit;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kmer_q     <= kmer;
			from_rev_q <= from_rev;
		end
	end

	assign out_valid      = out_valid_q;
	assign canonical_kmer = kmer_q;
	assign from_reverse   = from_rev_q;

	a_rev_needs_canon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!from_reverse || canon_q))
		else $error("reverse complement chosen outside canonical mode");

	a_kmer_fits_k: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((canonical_kmer >> {keff, 1'b0}) == '0))
		else $error("k-mer has bits above 2k");

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |-> (out_valid && !out_ready))
		else $error("input stalled while output slot free");

	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit) |=> out_valid)
		else $error("emitted k-mer lost");

endmodule
